// ===== rtl/keyed_max_bid_table_defines.svh =====
// assertion macros shared by the keyed max bid table rtl
// no dependencies; included by files that carry assertions
`ifndef KEYED_MAX_BID_TABLE_DEFINES_SVH
`define KEYED_MAX_BID_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// condition on the left implies condition on the right in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (con)) \
    else $error("assertion failed");
// condition on the left implies condition on the right in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (con)) \
    else $error("assertion failed");
// condition never holds
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, con)
`define ASSERT_NEXT(lbl, clk, rstn, pre, con)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/kmbt_pkg.sv =====
// shared types and constants for the keyed max bid table
// no dependencies
package kmbt_pkg;

  // fixed port widths
  localparam int OP_W     = 2;
  localparam int ID_W     = 6;
  localparam int AMT_IN_W = 32;

  // command queue depth
  localparam int QUEUE_DEPTH = 2;

  // opcodes on op_i
  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // classified command kinds passed from front to back
  typedef enum logic [1:0] {
    K_SET,
    K_REMOVE,
    K_QUERY,
    K_MISS
  } kind_e;

  localparam int KIND_W = $bits(kind_e);

  // back end state
  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_DRAIN
  } back_state_e;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/kmbt_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module kmbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kmbt_front.sv =====
// front end: classifies accepted commands and computes table addresses
// depends on kmbt_pkg
module kmbt_front
  import kmbt_pkg::*;
#(
  parameter int NUM_USERS   = 64,
  parameter int NUM_ITEMS   = 64,
  parameter int AMOUNT_BITS = 32,
  parameter int AW          = 12
) (
  input  logic                   accept_i,
  input  logic [OP_W-1:0]        op_i,
  input  logic [ID_W-1:0]        user_i,
  input  logic [ID_W-1:0]        item_i,
  input  logic [AMT_IN_W-1:0]    amount_i,
  output logic                   push_o,
  output kind_e                  kind_o,
  output logic [AW-1:0]          addr_o,
  output logic [AMOUNT_BITS-1:0] amount_o
);

  localparam int XW = AW + ID_W + 1;

  logic          user_ok;
  logic          item_ok;
  logic [XW-1:0] slot;

  // range checks against the table dimensions
  assign user_ok = 32'(user_i) < 32'(NUM_USERS);
  assign item_ok = 32'(item_i) < 32'(NUM_ITEMS);

  // slot address; a query starts at the item's first user
  assign slot = XW'(item_i) * XW'(NUM_USERS) + ((op_i == OP_QUERY) ? XW'(0) : XW'(user_i));

  assign addr_o   = slot[AW-1:0];
  assign amount_o = AMOUNT_BITS'(amount_i);

  // classification; ignored commands are dropped here
  always_comb begin
    push_o = 1'b0;
    kind_o = K_MISS;
    case (op_i)
      OP_SET: begin
        push_o = accept_i && user_ok && item_ok;
        kind_o = K_SET;
      end
      OP_REMOVE: begin
        push_o = accept_i && user_ok && item_ok;
        kind_o = K_REMOVE;
      end
      OP_QUERY: begin
        push_o = accept_i;
        kind_o = item_ok ? K_QUERY : K_MISS;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/kmbt_queue.sv =====
// small command queue between front and back ends
// depends on kmbt_pkg
`include "keyed_max_bid_table_defines.svh"
module kmbt_queue
  import kmbt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output queue_status_t    status_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = entry_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && !pop_i && status_o.full)
  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && status_o.empty)
  `ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + CW'(1))

endmodule

// ===== rtl/kmbt_back.sv =====
// back end: clears the table after reset, applies writes and scans queries
// depends on kmbt_pkg, kmbt_ram
`include "keyed_max_bid_table_defines.svh"
module kmbt_back
  import kmbt_pkg::*;
#(
  parameter int NUM_USERS   = 64,
  parameter int NUM_ITEMS   = 64,
  parameter int AMOUNT_BITS = 32,
  parameter int AW          = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  queue_status_t          qstat_i,
  input  kind_e                  kind_i,
  input  logic [AW-1:0]          addr_i,
  input  logic [AMOUNT_BITS-1:0] amount_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  output logic                   done_o,
  output logic                   found_o,
  output logic [ID_W-1:0]        bidder_o
);

  localparam int DEPTH = NUM_USERS * NUM_ITEMS;
  localparam int UW    = $clog2(NUM_USERS);
  localparam int DW    = AMOUNT_BITS + 1;

  back_state_e state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [AW-1:0]          rd_addr_q, rd_addr_d;
  logic [UW-1:0]          cnt_q, cnt_d;
  logic [UW-1:0]          tag_q, tag_d;
  logic                   pend_q, pend_d;
  logic                   best_found_q, best_found_d;
  logic [AMOUNT_BITS-1:0] best_amt_q, best_amt_d;
  logic [UW-1:0]          best_user_q, best_user_d;
  logic                   done_q, done_d;
  logic                   res_found_q, res_found_d;
  logic [ID_W-1:0]        res_bidder_q, res_bidder_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata;
  logic          take;

  // entry layout: valid mark on top, amount below
  kmbt_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  // running maximum; ties go to the later, larger user
  assign take = pend_q && rdata[DW-1]
             && (!best_found_q || (rdata[AMOUNT_BITS-1:0] >= best_amt_q));

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    rd_addr_d    = rd_addr_q;
    cnt_d        = cnt_q;
    tag_d        = cnt_q;
    pend_d       = 1'b0;
    best_found_d = best_found_q || take;
    best_amt_d   = take ? rdata[AMOUNT_BITS-1:0] : best_amt_q;
    best_user_d  = take ? tag_q : best_user_q;
    done_d       = 1'b0;
    res_found_d  = res_found_q;
    res_bidder_d = res_bidder_q;
    pop_o        = 1'b0;
    we           = 1'b0;
    waddr        = addr_i;
    wdata        = '0;
    case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = B_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      B_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          case (kind_i)
            K_SET: begin
              we    = 1'b1;
              wdata = {1'b1, amount_i};
            end
            K_REMOVE: begin
              we = 1'b1;
            end
            K_QUERY: begin
              rd_addr_d    = addr_i;
              cnt_d        = '0;
              best_found_d = 1'b0;
              state_d      = B_SCAN;
            end
            K_MISS: begin
              done_d       = 1'b1;
              res_found_d  = 1'b0;
              res_bidder_d = '0;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      B_SCAN: begin
        pend_d    = 1'b1;
        rd_addr_d = rd_addr_q + AW'(1);
        if (cnt_q == UW'(NUM_USERS - 1)) begin
          state_d = B_DRAIN;
        end else begin
          cnt_d = cnt_q + UW'(1);
        end
      end
      B_DRAIN: begin
        done_d      = 1'b1;
        res_found_d = best_found_q || take;
        if (take) begin
          res_bidder_d = ID_W'(tag_q);
        end else if (best_found_q) begin
          res_bidder_d = ID_W'(best_user_q);
        end else begin
          res_bidder_d = '0;
        end
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_CLEAR;
      clr_q        <= '0;
      pend_q       <= 1'b0;
      best_found_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      pend_q       <= pend_d;
      best_found_q <= best_found_d;
      done_q       <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    cnt_q        <= cnt_d;
    tag_q        <= tag_d;
    best_amt_q   <= best_amt_d;
    best_user_q  <= best_user_d;
    res_found_q  <= res_found_d;
    res_bidder_q <= res_bidder_d;
  end

  assign clearing_o = (state_q == B_CLEAR);
  assign done_o     = done_q;
  assign found_o    = res_found_q;
  assign bidder_o   = res_bidder_q;

  `ASSERT_IMPLIES(a_drain_has_read, clk_i, rst_ni, state_q == B_DRAIN, pend_q)
  `ASSERT_NEXT(a_query_scans, clk_i, rst_ni, pop_o && kind_i == K_QUERY, state_q == B_SCAN)
  `ASSERT_IMPLIES(a_empty_result, clk_i, rst_ni, done_q && !res_found_q, res_bidder_q == '0)

endmodule

// ===== rtl/keyed_max_bid_table.sv =====
// top level of the keyed max bid table: front end, command queue, back end
// depends on kmbt_pkg, kmbt_front, kmbt_queue, kmbt_back
//
// channel   direction  signals                               transfer
// command   in         start, busy, op_i, user_i,            start high, busy low
//                      item_i, amount_i
// result    out        done_o, found_o, bidder_o             done_o high, one cycle
//
// set and remove write the table from the back end idle state; a query reads
// the table once per user, then makes a final compare; a query on an item
// out of range answers without reading the table. the front end takes a
// command every cycle while the two entry queue has room and the table is
// not being cleared. after reset busy stays high while the table is cleared one
// entry per cycle. results are registered and leave regardless of the receiver.
module keyed_max_bid_table
  import kmbt_pkg::*;
#(
  parameter int NUM_USERS   = 64,
  parameter int NUM_ITEMS   = 64,
  parameter int AMOUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op_i,
  input  logic [ID_W-1:0]     user_i,
  input  logic [ID_W-1:0]     item_i,
  input  logic [AMT_IN_W-1:0] amount_i,
  output logic                done_o,
  output logic                found_o,
  output logic [ID_W-1:0]     bidder_o
);

  localparam int AW = $clog2(NUM_USERS * NUM_ITEMS);
  localparam int EW = KIND_W + AW + AMOUNT_BITS;

  logic                   accept;
  logic                   push;
  kind_e                  push_kind;
  logic [AW-1:0]          push_addr;
  logic [AMOUNT_BITS-1:0] push_amount;
  logic [EW-1:0]          pop_data;
  logic                   pop;
  queue_status_t          qstat;
  logic                   clearing;

  // command transfer
  assign busy   = clearing || qstat.full;
  assign accept = start && !busy;

  kmbt_front #(
    .NUM_USERS   (NUM_USERS),
    .NUM_ITEMS   (NUM_ITEMS),
    .AMOUNT_BITS (AMOUNT_BITS),
    .AW          (AW)
  ) u_front (
    .accept_i (accept),
    .op_i     (op_i),
    .user_i   (user_i),
    .item_i   (item_i),
    .amount_i (amount_i),
    .push_o   (push),
    .kind_o   (push_kind),
    .addr_o   (push_addr),
    .amount_o (push_amount)
  );

  kmbt_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_kind, push_addr, push_amount}),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (qstat)
  );

  kmbt_back #(
    .NUM_USERS   (NUM_USERS),
    .NUM_ITEMS   (NUM_ITEMS),
    .AMOUNT_BITS (AMOUNT_BITS),
    .AW          (AW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qstat_i    (qstat),
    .kind_i     (kind_e'(pop_data[EW-1 -: KIND_W])),
    .addr_i     (pop_data[AW+AMOUNT_BITS-1 -: AW]),
    .amount_i   (pop_data[AMOUNT_BITS-1:0]),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .found_o    (found_o),
    .bidder_o   (bidder_o)
  );

endmodule
